// File: hdl/prd_pkg.sv
// Shared types, constants and helpers for the pulse rate detector.
package prd_pkg;

    localparam int WINDOW = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_BITS = 16;
    localparam int DIV_CW = $clog2(DIV_BITS);

    localparam logic [1:0] REG_ALPHA_Q8 = 2'd0;
    localparam logic [1:0] REG_FRAME_LENGTH = 2'd1;
    localparam logic [1:0] REG_RATE_NUMERATOR = 2'd2;

    localparam logic [7:0] ALPHA_Q8_RST = 8'd230;
    localparam logic [7:0] FRAME_LENGTH_RST = 8'd43;
    localparam logic [15:0] RATE_NUMERATOR_RST = 16'd60000;

    localparam logic signed [15:0] FRAME_MAX_RST = 16'sh8000;
    localparam logic signed [15:0] FRAME_MIN_RST = 16'sh7FFF;
    localparam logic [15:0] RATE_SAT = 16'hFFFF;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic [15:0] time_stamp;
    } prd_in_t;

    typedef struct packed {
        logic signed [15:0] filtered_out;
        logic peak_found;
        logic [15:0] beat_rate;
        logic [15:0] beat_interval;
    } prd_out_t;

    typedef struct packed {
        logic [7:0] alpha_q8;
        logic [7:0] frame_length;
        logic [15:0] rate_numerator;
    } prd_cfg_t;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic peak;
        logic [15:0] interval;
        logic [15:0] numerator;
    } prd_job_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/prd_front.sv
// Front end: DC filter, frame min/max, slope window, peak test and beat interval.
module prd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  prd_pkg::prd_in_t  sample,
    input  prd_pkg::prd_cfg_t cfg,
    output logic              job_valid,
    input  logic              job_ready,
    output prd_pkg::prd_job_t job
);
    import prd_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL  = 6'b000010,
        F_SUM  = 6'b000100,
        F_DIFF = 6'b001000,
        F_DET  = 6'b010000,
        F_PUSH = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic signed [15:0] x_reg, x_next;
    logic [15:0] ts_reg, ts_next;
    logic signed [24:0] prod_reg, prod_next;
    logic signed [15:0] w_reg, w_next;
    logic signed [15:0] y_reg, y_next;
    logic peak_reg, peak_next;
    logic signed [15:0] dc_prev_reg, dc_prev_next;
    logic signed [15:0] win_reg [WINDOW];
    logic signed [15:0] win_next [WINDOW];
    logic signed [15:0] frame_max_reg, frame_max_next;
    logic signed [15:0] frame_min_reg, frame_min_next;
    logic [15:0] range_reg, range_next;
    logic [7:0] frame_count_reg, frame_count_next;
    logic [15:0] last_peak_reg, last_peak_next;
    logic [15:0] interval_reg, interval_next;

    always_comb
    begin
        logic signed [16:0] q;
        logic signed [17:0] diff;
        logic signed [16:0] slope;
        logic signed [16:0] half;
        logic [7:0] cnt;

        state_next = state_reg;
        x_next = x_reg;
        ts_next = ts_reg;
        prod_next = prod_reg;
        w_next = w_reg;
        y_next = y_reg;
        peak_next = peak_reg;
        dc_prev_next = dc_prev_reg;
        win_next = win_reg;
        frame_max_next = frame_max_reg;
        frame_min_next = frame_min_reg;
        range_next = range_reg;
        frame_count_next = frame_count_reg;
        last_peak_next = last_peak_reg;
        interval_next = interval_reg;

        q = prod_reg[24:8];
        if (prod_reg[24] && (prod_reg[7:0] != 8'd0))
        begin
            q = q + 17'sd1;
        end
        diff = {w_reg[15], w_reg[15], w_reg} - {dc_prev_reg[15], dc_prev_reg[15], dc_prev_reg};
        slope = {win_reg[0][15], win_reg[0]} - {win_reg[WINDOW-1][15], win_reg[WINDOW-1]};
        half = {2'b00, range_reg[15:1]};
        cnt = frame_count_reg + 8'd1;

        sample_ready = (state_reg == F_IDLE);
        job_valid = (state_reg == F_PUSH);

        case (state_reg)
            F_IDLE:
            begin
                if (sample_valid)
                begin
                    x_next = sample.sample_in;
                    ts_next = sample.time_stamp;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                prod_next = 25'($signed({1'b0, cfg.alpha_q8})) * 25'(dc_prev_reg);
                state_next = F_SUM;
            end
            F_SUM:
            begin
                w_next = sat16({x_reg[15], x_reg[15], x_reg} + {q[16], q});
                state_next = F_DIFF;
            end
            F_DIFF:
            begin
                y_next = sat16(diff);
                dc_prev_next = w_reg;
                if (y_next < frame_min_reg)
                begin
                    frame_min_next = y_next;
                end
                if (y_next > frame_max_reg)
                begin
                    frame_max_next = y_next;
                end
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[WINDOW-1] = y_next;
                state_next = F_DET;
            end
            F_DET:
            begin
                peak_next = 1'b0;
                if (slope >= half)
                begin
                    peak_next = 1'b1;
                    for (int i = 0; i < WINDOW; i++)
                    begin
                        win_next[i] = '0;
                    end
                    interval_next = ts_reg - last_peak_reg;
                    last_peak_next = ts_reg;
                end
                frame_count_next = cnt;
                if (cnt >= cfg.frame_length)
                begin
                    range_next = frame_max_reg - frame_min_reg;
                    frame_max_next = FRAME_MAX_RST;
                    frame_min_next = FRAME_MIN_RST;
                    frame_count_next = '0;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign job.filtered = y_reg;
    assign job.peak = peak_reg;
    assign job.interval = interval_reg;
    assign job.numerator = cfg.rate_numerator;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            dc_prev_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            frame_max_reg <= FRAME_MAX_RST;
            frame_min_reg <= FRAME_MIN_RST;
            range_reg <= '0;
            frame_count_reg <= '0;
            last_peak_reg <= '0;
            interval_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dc_prev_reg <= dc_prev_next;
            win_reg <= win_next;
            frame_max_reg <= frame_max_next;
            frame_min_reg <= frame_min_next;
            range_reg <= range_next;
            frame_count_reg <= frame_count_next;
            last_peak_reg <= last_peak_next;
            interval_reg <= interval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        ts_reg <= ts_next;
        prod_reg <= prod_next;
        w_reg <= w_next;
        y_reg <= y_next;
        peak_reg <= peak_next;
    end

endmodule

// File: hdl/prd_queue.sv
// Small job queue between the front end and the rate divider.
module prd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  prd_pkg::prd_job_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output prd_pkg::prd_job_t pop_data
);
    import prd_pkg::*;

    prd_job_t mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/prd_back.sv
// Back end: restoring divider for the beat rate and the result register.
module prd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  prd_pkg::prd_job_t job,
    output logic              result_valid,
    input  logic              result_ready,
    output prd_pkg::prd_out_t result
);
    import prd_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic signed [15:0] y_reg, y_next;
    logic peak_reg, peak_next;
    logic [15:0] divisor_reg, divisor_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    prd_out_t out_reg, out_next;

    always_comb
    begin
        logic [16:0] trial;
        logic [16:0] sub;

        state_next = state_reg;
        y_next = y_reg;
        peak_next = peak_reg;
        divisor_next = divisor_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;

        trial = {rem_reg, quo_reg[DIV_BITS-1]};
        sub = trial - {1'b0, divisor_reg};

        job_ready = (state_reg == B_IDLE);

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    y_next = job.filtered;
                    peak_next = job.peak;
                    divisor_next = job.interval;
                    rem_next = '0;
                    cnt_next = '0;
                    if (job.interval == 16'd0)
                    begin
                        quo_next = RATE_SAT;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        quo_next = job.numerator;
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_next = sub[15:0];
                    quo_next = {quo_reg[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[15:0];
                    quo_next = {quo_reg[DIV_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_BITS - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.filtered_out = y_reg;
                    out_next.peak_found = peak_reg;
                    out_next.beat_rate = quo_reg;
                    out_next.beat_interval = divisor_reg;
                    out_valid_next = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
        peak_reg <= peak_next;
        divisor_reg <= divisor_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        out_reg <= out_next;
    end

endmodule

// File: hdl/pulse_rate_detector_core.sv
// Top level of the pulse rate detector: configuration registers, front end, queue, back end.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  sample   | sample_valid/sample_ready  | sample (sample_in, time_stamp)
//  result   | result_valid/result_ready  | result (filtered_out, peak_found, ...)
//  cfg      | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// The front end handles one sample at a time (multiply, add, subtract, detect, hand-off).
// The back end runs each item through the 16-step restoring rate divider; with a zero
// interval it skips the divider and saturates the rate. It takes a new item only when idle.
// A two-entry queue lets the front end keep taking samples while the divider is busy,
// and the divider keeps running while a result waits in the output register.
// rst_n clears all control and filter state; cfg_ready is always high.
module pulse_rate_detector_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  prd_pkg::prd_in_t  sample,
    output logic              result_valid,
    input  logic              result_ready,
    output prd_pkg::prd_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import prd_pkg::*;

    prd_cfg_t cfg_reg;
    prd_job_t front_job, queue_job;
    logic front_valid, front_ready;
    logic queue_valid, queue_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_q8 <= ALPHA_Q8_RST;
            cfg_reg.frame_length <= FRAME_LENGTH_RST;
            cfg_reg.rate_numerator <= RATE_NUMERATOR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALPHA_Q8:       cfg_reg.alpha_q8 <= cfg_data[7:0];
                REG_FRAME_LENGTH:   cfg_reg.frame_length <= cfg_data[7:0];
                REG_RATE_NUMERATOR: cfg_reg.rate_numerator <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    prd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .cfg          (cfg_reg),
        .job_valid    (front_valid),
        .job_ready    (front_ready),
        .job          (front_job)
    );

    prd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_job)
    );

    prd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (queue_valid),
        .job_ready    (queue_ready),
        .job          (queue_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: sim/prd_checker.sv
// Predicts detector outputs from observed transfers and checks each result transfer.
`timescale 1ns / 100ps
module prd_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_ready,
    input  prd_pkg::prd_in_t  sample,
    input  logic              result_valid,
    input  logic              result_ready,
    input  prd_pkg::prd_out_t result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output int                mismatches,
    output int                outstanding,
    output int                checked,
    output int                beats
);
    import prd_pkg::*;

    logic [7:0]         alpha;
    logic [7:0]         flen;
    logic [15:0]        numer;

    logic signed [15:0] dc_w;
    logic signed [15:0] win [WINDOW];
    logic signed [15:0] fmax;
    logic signed [15:0] fmin;
    logic [15:0]        range_q;
    logic [7:0]         fcount;
    logic [15:0]        last_ts;
    logic [15:0]        interval;

    prd_out_t           predicted_out [$];

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Advances the detector state by one sample and returns its output.
    function automatic prd_out_t detect_step(input prd_in_t s);
        int                 prod;
        int                 slope;
        logic signed [15:0] w;
        logic signed [15:0] y;
        prd_out_t           o;
        o = '0;
        prod = (int'(alpha) * int'(dc_w)) / 256;
        w = clip16(int'(s.sample_in) + prod);
        y = clip16(int'(w) - int'(dc_w));
        dc_w = w;
        if (y < fmin)
        begin
            fmin = y;
        end
        if (y > fmax)
        begin
            fmax = y;
        end
        for (int i = 1; i < WINDOW; i++)
        begin
            win[i - 1] = win[i];
        end
        win[WINDOW - 1] = y;
        slope = int'(win[0]) - int'(win[WINDOW - 1]);
        o.peak_found = (slope >= int'(range_q >> 1));
        if (o.peak_found)
        begin
            foreach (win[i])
            begin
                win[i] = '0;
            end
            interval = s.time_stamp - last_ts;
            last_ts = s.time_stamp;
        end
        o.filtered_out = y;
        o.beat_interval = interval;
        o.beat_rate = (interval == 16'd0) ? RATE_SAT : 16'(numer / interval);
        fcount = fcount + 8'd1;
        if (fcount >= flen)
        begin
            range_q = 16'(int'(fmax) - int'(fmin));
            fmax = FRAME_MAX_RST;
            fmin = FRAME_MIN_RST;
            fcount = '0;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        prd_out_t want;
        prd_out_t got;
        int       errs;
        errs = 0;
        if (!rst_n)
        begin
            alpha = ALPHA_Q8_RST;
            flen = FRAME_LENGTH_RST;
            numer = RATE_NUMERATOR_RST;
            dc_w = '0;
            foreach (win[i])
            begin
                win[i] = '0;
            end
            fmax = FRAME_MAX_RST;
            fmin = FRAME_MIN_RST;
            range_q = '0;
            fcount = '0;
            last_ts = '0;
            interval = '0;
            predicted_out.delete();
            mismatches <= 0;
            outstanding <= 0;
            checked <= 0;
            beats <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ALPHA_Q8:       alpha = cfg_data[7:0];
                    REG_FRAME_LENGTH:   flen = cfg_data[7:0];
                    REG_RATE_NUMERATOR: numer = cfg_data;
                    default:            ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                got = result;
                if (predicted_out.size() == 0)
                begin
                    $error("result transfer with no sample outstanding");
                    errs++;
                end
                else
                begin
                    want = predicted_out.pop_front();
                    if (got.filtered_out !== want.filtered_out)
                    begin
                        $error("filtered_out expected %0d actual %0d",
                               want.filtered_out, got.filtered_out);
                        errs++;
                    end
                    if (got.peak_found !== want.peak_found)
                    begin
                        $error("peak_found expected %0b actual %0b",
                               want.peak_found, got.peak_found);
                        errs++;
                    end
                    if (got.beat_rate !== want.beat_rate)
                    begin
                        $error("beat_rate expected %0d actual %0d",
                               want.beat_rate, got.beat_rate);
                        errs++;
                    end
                    if (got.beat_interval !== want.beat_interval)
                    begin
                        $error("beat_interval expected %0d actual %0d",
                               want.beat_interval, got.beat_interval);
                        errs++;
                    end
                end
                checked <= checked + 1;
            end
            if (sample_valid && sample_ready)
            begin
                want = detect_step(sample);
                predicted_out.push_back(want);
                beats <= beats + int'(want.peak_found);
            end
            mismatches <= mismatches + errs;
            outstanding <= predicted_out.size();
        end
    end

endmodule

// File: sim/tb_pulse_rate_detector_core.sv
// Testbench top: drives samples, register writes and result back-pressure, gives the verdict.
`timescale 1ns / 100ps
module tb_pulse_rate_detector_core;
    import prd_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    prd_in_t     sample = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    prd_out_t    result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_ALPHA_Q8;
    logic [15:0] cfg_data = '0;

    int          mismatches;
    int          outstanding;
    int          checked;
    int          beats;

    int          items_sent = 0;
    int          reg_writes = 0;
    int          wave_pos = 0;
    int          wave_period = 20;
    int          wave_amp = 1000;
    int          wave_dc = 0;
    logic [15:0] ts_now = '0;

    prd_in_t corner_samples [16] = '{
        '{16'sh7FFF, 16'd0},     '{16'sh7FFF, 16'd0},     '{16'sh8000, 16'd1},
        '{16'sh8000, 16'd1},     '{16'sh0000, 16'hFFFF},  '{16'shFFFF, 16'hFFFF},
        '{16'sh5555, 16'hAAAA},  '{16'shAAAA, 16'h5555},  '{16'sh0001, 16'd2},
        '{16'shFFFE, 16'd3},     '{16'sh7FFF, 16'hFFFE},  '{16'sh8000, 16'hFFFF},
        '{16'sh0000, 16'd0},     '{16'sh4000, 16'd20},    '{16'shC000, 16'd20},
        '{16'sh0000, 16'd40}
    };

    always #6 clk = ~clk;

    pulse_rate_detector_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    prd_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .beats        (beats)
    );

    function automatic void new_waveform();
        wave_period = $urandom_range(40, 8);
        wave_amp = $urandom_range(16000, 50);
        wave_dc = int'($urandom_range(40000)) - 20000;
        wave_pos = 0;
    endfunction

    // Mostly pulse-like sawtooth with noise and steady ticks; some raw noise, some rail hits
    // that keep the time stamp still.
    function automatic prd_in_t make_sample();
        prd_in_t     s;
        int          v;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            wave_pos = (wave_pos + 1) % wave_period;
            v = wave_dc + wave_amp - (2 * wave_amp * wave_pos) / wave_period
                + int'($urandom_range(64)) - 32;
            if (v > 32767)
            begin
                v = 32767;
            end
            else if (v < -32768)
            begin
                v = -32768;
            end
            s.sample_in = v[15:0];
            ts_now = ts_now + 16'($urandom_range(24, 16));
        end
        else if (pick < 85)
        begin
            s.sample_in = 16'($urandom);
            ts_now = 16'($urandom);
        end
        else
        begin
            s.sample_in = pick[0] ? 16'sh7FFF : 16'sh8000;
        end
        s.time_stamp = ts_now;
        return s;
    endfunction

    task automatic send_sample(input prd_in_t s);
        sample_valid <= 1'b1;
        sample <= s;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ready);
        items_sent++;
        if ((items_sent < 300 || items_sent >= 380) && $urandom_range(99) < 18)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it once the last write is done.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        reg_writes++;
    endtask

    task automatic program_regs(input logic [7:0] a, input logic [7:0] f, input logic [15:0] n);
        write_reg(REG_ALPHA_Q8, {8'($urandom), a});
        write_reg(REG_FRAME_LENGTH, {8'($urandom), f});
        write_reg(REG_RATE_NUMERATOR, n);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n);
        new_waveform();
        for (int i = 0; i < n; i++)
        begin
            send_sample(make_sample());
        end
        sample_valid <= 1'b0;
        wait_all_results();
    endtask

    // Receiver: random stalls, one long hold-off while samples keep coming, one quiet stretch.
    initial
    begin : receiver
        int unsigned taken;
        int unsigned hold_left;
        bit          held;
        taken = 0;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                taken++;
            end
            if (!held && taken >= 150 && sample_valid)
            begin
                held = 1'b1;
                hold_left = 300;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (taken >= 280 && taken < 380)
            begin
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_samples[i])
        begin
            send_sample(corner_samples[i]);
        end
        sample_valid <= 1'b0;
        wait_all_results();

        program_regs(8'd0, 8'd1, 16'd1);
        run_random(50);
        program_regs(8'd255, 8'd255, 16'hFFFF);
        run_random(60);
        // frame length zero latches every sample; zero numerator
        program_regs(8'd230, 8'd0, 16'd0);
        run_random(40);

        // frame length lowered below the running count
        program_regs(8'($urandom), 8'd200, 16'($urandom));
        run_random(50);
        write_reg(REG_FRAME_LENGTH, 16'd7);
        write_reg(REG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
        run_random(40);

        repeat (5)
        begin
            program_regs(8'($urandom), 8'($urandom_range(60, 1)), 16'($urandom));
            run_random(25);
            run_random(25);
        end

        repeat (40) @(posedge clk);
        $display("covered %0d results (%0d beats) across %0d register writes",
                 checked, beats, reg_writes);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin : watchdog
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
